/* sv/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, types and constants of the quaternion vector rotator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

  // Field width of every quaternion and vector component.
  localparam int unsigned CompW = 32;
  // Quadratic product of two components.
  localparam int unsigned ProdW = 2 * CompW;
  // Rotation matrix coefficient: sum of four products, or twice a sum or difference.
  localparam int unsigned CoefW = ProdW + 2;
  // Low part of a coefficient taken as unsigned in the split multiply.
  localparam int unsigned LoW   = CoefW / 2;
  localparam int unsigned HiW   = CoefW - LoW;
  // Partial products of the split multiply.
  localparam int unsigned PLoW  = LoW + 1 + CompW;
  localparam int unsigned PHiW  = HiW + CompW;
  // Exact dot product of a matrix row with the vector, with headroom.
  localparam int unsigned SumW  = CoefW + CompW + 2;
  // Scale of the exact sum is 2^76; Q16.16 output keeps 2^16.
  localparam int unsigned FracShift = 60;
  localparam int unsigned RndW  = SumW - FracShift;

  // Register stages from input to output; the last one is the output register.
  localparam int unsigned NumStages = 6;

  localparam logic signed [SumW-1:0] RoundBias = SumW'(1) <<< (FracShift - 1);

  localparam logic signed [CompW-1:0] SatMax = {1'b0, {(CompW-1){1'b1}}};
  localparam logic signed [CompW-1:0] SatMin = {1'b1, {(CompW-1){1'b0}}};

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [PLoW-1:0]  plo_t;
  typedef logic signed [PHiW-1:0]  phi_t;
  typedef logic signed [SumW-1:0]  sum_t;

  // Load enables of the stages before the output register, one per stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage : qvr_pkg

`default_nettype wire

/* sv/qvr_coef.sv */
// ----------------------------------------------------------------------------
// qvr_coef
// Quadratic products of the quaternion and the 3x3 rotation coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qvr_coef (
  input  wire                 clk,
  input  qvr_pkg::stage_en_t  en,
  input  qvr_pkg::comp_t      rot_w,
  input  qvr_pkg::comp_t      rot_x,
  input  qvr_pkg::comp_t      rot_y,
  input  qvr_pkg::comp_t      rot_z,
  output qvr_pkg::coef_t      coef_o [3][3]
);

  import qvr_pkg::*;

  prod_t ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  coef_t coef_r [3][3];
  coef_t coef_nxt [3][3];

  // First stage: the ten distinct products, one multiplier each.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      ww_r <= rot_w * rot_w;
      xx_r <= rot_x * rot_x;
      yy_r <= rot_y * rot_y;
      zz_r <= rot_z * rot_z;
      xy_r <= rot_x * rot_y;
      xz_r <= rot_x * rot_z;
      yz_r <= rot_y * rot_z;
      wx_r <= rot_w * rot_x;
      wy_r <= rot_w * rot_y;
      wz_r <= rot_w * rot_z;
    end
  end

  // Second stage: matrix entries of q (0,v) conj(q), exact.
  always_comb begin
    coef_nxt[0][0] = CoefW'(ww_r) + CoefW'(xx_r) - CoefW'(yy_r) - CoefW'(zz_r);
    coef_nxt[0][1] = (CoefW'(xy_r) - CoefW'(wz_r)) <<< 1;
    coef_nxt[0][2] = (CoefW'(xz_r) + CoefW'(wy_r)) <<< 1;
    coef_nxt[1][0] = (CoefW'(xy_r) + CoefW'(wz_r)) <<< 1;
    coef_nxt[1][1] = CoefW'(ww_r) - CoefW'(xx_r) + CoefW'(yy_r) - CoefW'(zz_r);
    coef_nxt[1][2] = (CoefW'(yz_r) - CoefW'(wx_r)) <<< 1;
    coef_nxt[2][0] = (CoefW'(xz_r) - CoefW'(wy_r)) <<< 1;
    coef_nxt[2][1] = (CoefW'(yz_r) + CoefW'(wx_r)) <<< 1;
    coef_nxt[2][2] = CoefW'(ww_r) - CoefW'(xx_r) - CoefW'(yy_r) + CoefW'(zz_r);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      coef_r <= coef_nxt;
    end
  end

  assign coef_o = coef_r;

endmodule : qvr_coef

`default_nettype wire

/* sv/qvr_dot.sv */
// ----------------------------------------------------------------------------
// qvr_dot
// Exact dot product of one coefficient row with the vector, three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qvr_dot (
  input  wire                 clk,
  input  qvr_pkg::stage_en_t  en,
  input  qvr_pkg::coef_t      coef_i [3],
  input  qvr_pkg::comp_t      vec_i  [3],
  output qvr_pkg::sum_t       sum_o
);

  import qvr_pkg::*;

  plo_t lo_r   [3];
  phi_t hi_r   [3];
  sum_t term_r [3];
  sum_t sum_r;

  // Each wide coefficient is split into an unsigned low half and a signed
  // high half, so that every multiplier stays near 33 by 32 bits.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int j = 0; j < 3; j++) begin
        lo_r[j] <= $signed({1'b0, coef_i[j][LoW-1:0]}) * vec_i[j];
        hi_r[j] <= $signed(coef_i[j][CoefW-1:LoW]) * vec_i[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int j = 0; j < 3; j++) begin
        term_r[j] <= (SumW'(hi_r[j]) <<< LoW) + SumW'(lo_r[j]);
      end
    end
  end

  // The rounding bias rides along with the row sum.
  always_ff @(posedge clk) begin
    if (en.s5) begin
      sum_r <= term_r[0] + term_r[1] + term_r[2] + RoundBias;
    end
  end

  assign sum_o = sum_r;

endmodule : qvr_dot

`default_nettype wire

/* sv/quaternion_vector_rotate.sv */
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a Q16.16 3-vector by a Q2.30 quaternion, one item per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Each input item carries a quaternion q = (w, x, y, z) in signed Q2.30 and a
// vector v in signed Q16.16; the block returns the vector part of
// q (0, v) conj(q) in signed Q16.16. The quaternion is used as given, so a
// non-unit q also scales the result by its squared norm. The product is
// formed exactly, rounded once to nearest (halves toward plus infinity) and
// saturated to the 32-bit range. The block accepts one item every clock while
// the output is not stalled; each item passes through its six register
// stages in order: quadratic products, matrix coefficients, split partial
// products, row terms, row sums, and the rounded output register.
// Backpressure on the output stalls only the stages that hold data, so
// bubbles are squeezed out and up to six items are in flight.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotate (
  input  wire          clk,
  input  wire          rst_n,
  // Input item: rot_w, rot_x, rot_y, rot_z, vec_x, vec_y, vec_z, 32 bits
  // each, from the lowest bit up.
  input  wire  [223:0] in_tdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  // Result item: out_x, out_y, out_z, 32 bits each, from the lowest bit up.
  output logic [95:0]  out_tdata,
  output logic         out_tvalid,
  input  wire          out_tready
);

  import qvr_pkg::*;

  comp_t     rot_w, rot_x, rot_y, rot_z;
  comp_t     vec_in [3];
  comp_t     vec1_r [3];
  comp_t     vec2_r [3];
  coef_t     coef   [3][3];
  sum_t      sum    [3];
  comp_t     res_nxt [3];
  comp_t     res_r   [3];

  logic [NumStages-1:0] vld_r;
  logic [NumStages-1:0] vld_nxt;
  // rdy[k] means stage k+1 may load this cycle; the top bit is the sink.
  logic [NumStages:0]   rdy;
  stage_en_t            en;

  // Field unpacking, lowest field in the lowest bits.
  assign rot_w     = in_tdata[31:0];
  assign rot_x     = in_tdata[63:32];
  assign rot_y     = in_tdata[95:64];
  assign rot_z     = in_tdata[127:96];
  assign vec_in[0] = in_tdata[159:128];
  assign vec_in[1] = in_tdata[191:160];
  assign vec_in[2] = in_tdata[223:192];

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[NumStages] = out_tready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = rdy[k+1] || !vld_r[k];
    end
  end

  always_comb begin
    en.s1 = rdy[0];
    en.s2 = rdy[1];
    en.s3 = rdy[2];
    en.s4 = rdy[3];
    en.s5 = rdy[4];
  end

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NumStages-1];

  // The vector travels beside the coefficient stages.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      vec1_r <= vec_in;
    end
    if (en.s2) begin
      vec2_r <= vec1_r;
    end
  end

  qvr_coef u_coef (
    .clk    (clk),
    .en     (en),
    .rot_w  (rot_w),
    .rot_x  (rot_x),
    .rot_y  (rot_y),
    .rot_z  (rot_z),
    .coef_o (coef)
  );

  for (genvar r = 0; r < 3; r++) begin : g_row
    qvr_dot u_dot (
      .clk    (clk),
      .en     (en),
      .coef_i (coef[r]),
      .vec_i  (vec2_r),
      .sum_o  (sum[r])
    );
  end

  // Final stage: drop the fraction bits below Q16.16 and saturate. The sum
  // already carries the rounding bias, so an arithmetic shift rounds it.
  always_comb begin
    logic [RndW-1:0] q;
    for (int r = 0; r < 3; r++) begin
      q = sum[r][SumW-1:FracShift];
      if (q[RndW-1:CompW-1] == '0 || q[RndW-1:CompW-1] == '1) begin
        res_nxt[r] = q[CompW-1:0];
      end else if (q[RndW-1]) begin
        res_nxt[r] = SatMin;
      end else begin
        res_nxt[r] = SatMax;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NumStages-1]) begin
      res_r <= res_nxt;
    end
  end

  assign out_tdata = {res_r[2], res_r[1], res_r[0]};

  // An item accepted at the input always lands in the first stage.
  a_accept_lands : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item did not enter the first stage");

  // The input only stalls when every stage holds an item.
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (vld_r == '1))
    else $error("input stalled with an empty stage in the pipeline");

  // An item in the last row-sum stage reaches the output when it may move.
  a_sum_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NumStages-2] && rdy[NumStages-1] |=> out_tvalid)
    else $error("item lost between row sum and output");

  // A stalled output keeps its item and its data.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule : quaternion_vector_rotate

`default_nettype wire
